[rtl/hbad_pkg.sv]
// Shared types, codes and memory map constants for the bus address decoder.
`default_nettype none

package hbad_pkg;

    // Sizes of the internal byte stores.
    localparam int WORK_RAM_BYTES_C   = 8192;
    localparam int CART_RAM_BYTES_C   = 8192;
    localparam int HIGH_RAM_BYTES_C   = 128;
    localparam int SPRITE_RAM_BYTES_C = 160;

    // Bus command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Memory map landmarks.
    localparam logic [15:0] ADDR_OAM_BASE  = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_END   = 16'hFEA0;
    localparam logic [15:0] ADDR_IO_BASE   = 16'hFF00;
    localparam logic [15:0] ADDR_IRQ_FLAGS = 16'hFF0F;
    localparam logic [15:0] ADDR_VREG_BASE = 16'hFF40;
    localparam logic [15:0] ADDR_BOOT_OFF  = 16'hFF50;
    localparam logic [15:0] ADDR_HRAM_BASE = 16'hFF80;
    localparam logic [15:0] ADDR_IRQ_EN    = 16'hFFFF;
    localparam logic [15:0] ADDR_WRAM_MASK = 16'h1FFF;
    localparam logic [7:0]  BOOT_OFF_KEY   = 8'h01;
    localparam logic [7:0]  OPEN_BUS_BYTE  = 8'hFF;

    // Target codes of a decoded request.
    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_BOOT     = 3'd1,
        TGT_ROM      = 3'd2,
        TGT_VRAM     = 3'd3,
        TGT_VREG     = 3'd4,
        TGT_DROP     = 3'd5
    } t_hbad_target;

    // Request payload.
    typedef struct packed {
        logic        command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_hbad_req;

    // Response payload.
    typedef struct packed {
        logic [2:0]  target;
        logic [21:0] target_address;
        logic [7:0]  read_data;
        logic        forward_write;
        logic [7:0]  forward_data;
    } t_hbad_rsp;

    // Decoder controls and the response fields known at decode time.
    typedef struct packed {
        t_hbad_rsp rsp;
        logic      main_en;
        logic      small_en;
        logic      we;
        logic      ie_we;
        logic      if_we;
        logic      boot_clr;
    } t_hbad_dec;

    // Request in flight while the store read completes.
    typedef struct packed {
        t_hbad_rsp rsp;
        logic      rd_main;
        logic      rd_small;
    } t_hbad_s1;

endpackage

`default_nettype wire

[rtl/handheld_bus_address_decoder_core.sv]
// Top level of the handheld bus address decoder: request and response channels, stores.
`default_nettype none

// Decodes one byte bus request per cycle on a 16-bit address map. Cartridge and work
// RAM live in one 16K-byte synchronous main store, sprite and high RAM in a small
// store; the interrupt registers, the boot ROM mapping flag and the ROM bank are
// flip-flops. A request is decoded and its store access issued in the cycle it is
// accepted; the store's registered read data completes the response in the next
// cycle, and the response then waits in an output register behind the request
// stage, and a new request is taken every cycle while responses
// are taken. Stores start undefined: reading a byte never written returns garbage.
// ROM, video RAM and video registers are external; the response names the target,
// its address and any byte to forward. The ROM bank register may be written only
// while no request is in flight.
module handheld_bus_address_decoder_core #(
    parameter int WORK_RAM_BYTES   = hbad_pkg::WORK_RAM_BYTES_C,
    parameter int CART_RAM_BYTES   = hbad_pkg::CART_RAM_BYTES_C,
    parameter int HIGH_RAM_BYTES   = hbad_pkg::HIGH_RAM_BYTES_C,
    parameter int SPRITE_RAM_BYTES = hbad_pkg::SPRITE_RAM_BYTES_C
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire hbad_pkg::t_hbad_req i_req,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output hbad_pkg::t_hbad_rsp      o_rsp,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);

    import hbad_pkg::*;

    localparam int MAIN_DEPTH  = WORK_RAM_BYTES + CART_RAM_BYTES;
    localparam int SMALL_DEPTH = SPRITE_RAM_BYTES + HIGH_RAM_BYTES;
    localparam int MAIN_AW     = $clog2(MAIN_DEPTH);
    localparam int SMALL_AW    = $clog2(SMALL_DEPTH);

    logic [7:0]  r_rom_bank;
    logic        r_boot_mapped;
    logic [7:0]  r_irq_enable;
    logic [7:0]  r_irq_flags;
    logic        r_s1_valid;
    t_hbad_s1    r_s1;
    logic        r_out_valid;
    t_hbad_rsp   r_out;
    t_hbad_rsp   n_out;

    t_hbad_dec             dec;
    logic [MAIN_AW-1:0]    main_addr;
    logic [SMALL_AW-1:0]   small_addr;
    logic [7:0]            main_rdata;
    logic [7:0]            small_rdata;
    logic                  req_acc;
    logic                  out_load;

    // Handshakes: the held request moves on when the output register frees up.
    assign out_load    = r_s1_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_s1_valid || out_load;
    assign req_acc     = i_req_valid && o_req_ready;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    hbad_decode #(
        .CART_RAM_BYTES  (CART_RAM_BYTES),
        .SPRITE_RAM_BYTES(SPRITE_RAM_BYTES),
        .MAIN_AW         (MAIN_AW),
        .SMALL_AW        (SMALL_AW)
    ) u_decode (
        .i_req        (i_req),
        .i_rom_bank   (r_rom_bank),
        .i_boot_mapped(r_boot_mapped),
        .i_irq_enable (r_irq_enable),
        .i_irq_flags  (r_irq_flags),
        .o_dec        (dec),
        .o_main_addr  (main_addr),
        .o_small_addr (small_addr)
    );

    hbad_ram #(
        .DEPTH(MAIN_DEPTH),
        .AW   (MAIN_AW)
    ) u_main_ram (
        .i_clk  (i_clk),
        .i_en   (req_acc && dec.main_en),
        .i_we   (dec.we),
        .i_addr (main_addr),
        .i_wdata(i_req.write_data),
        .o_rdata(main_rdata)
    );

    hbad_ram #(
        .DEPTH(SMALL_DEPTH),
        .AW   (SMALL_AW)
    ) u_small_ram (
        .i_clk  (i_clk),
        .i_en   (req_acc && dec.small_en),
        .i_we   (dec.we),
        .i_addr (small_addr),
        .i_wdata(i_req.write_data),
        .o_rdata(small_rdata)
    );

    // Configuration and the register file of the map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank    <= 8'd1;
            r_boot_mapped <= 1'b1;
            r_irq_enable  <= '0;
            r_irq_flags   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_rom_bank <= i_cfg_data;
            end
            if (req_acc && dec.ie_we) begin
                r_irq_enable <= i_req.write_data;
            end
            if (req_acc && dec.if_we) begin
                r_irq_flags <= i_req.write_data;
            end
            if (req_acc && dec.boot_clr) begin
                r_boot_mapped <= 1'b0;
            end
        end
    end

    // Request stage waiting on the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_acc) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1.rsp      <= dec.rsp;
            r_s1.rd_main  <= dec.main_en && !dec.we;
            r_s1.rd_small <= dec.small_en && !dec.we;
        end
    end

    // Merge the store data into the response.
    always_comb begin
        n_out = r_s1.rsp;
        if (r_s1.rd_main) begin
            n_out.read_data = main_rdata;
        end else if (r_s1.rd_small) begin
            n_out.read_data = small_rdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // A request is taken while one is held only if the held one moves on.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && r_s1_valid |-> out_load)
        else $error("request accepted over a held request");

    // Once unmapped, the boot ROM stays unmapped until reset.
    a_boot_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_boot_mapped |=> !r_boot_mapped)
        else $error("boot ROM mapped again");

    // Only video RAM and video registers receive forwarded writes.
    a_fwd_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.forward_write |->
            (o_rsp.target == TGT_VRAM) || (o_rsp.target == TGT_VREG))
        else $error("forwarded write to a non-video target");

    // The two stores are never addressed by the same request.
    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> !(dec.main_en && dec.small_en))
        else $error("both stores selected");

    // A store read issued now completes the held request next cycle.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (dec.main_en || dec.small_en) && !dec.we |=>
            r_s1_valid && (r_s1.rd_main || r_s1.rd_small))
        else $error("store read lost its request");
`endif

endmodule

`default_nettype wire

[rtl/hbad_ram.sv]
// Single port synchronous byte RAM with registered read data.
`default_nettype none

module hbad_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write or read one byte; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/hbad_decode.sv]
// Address decoder: maps one bus request onto a target, a store and register updates.
`default_nettype none

module hbad_decode #(
    parameter int CART_RAM_BYTES   = 8192,
    parameter int SPRITE_RAM_BYTES = 160,
    parameter int MAIN_AW          = 14,
    parameter int SMALL_AW         = 9
) (
    input  wire hbad_pkg::t_hbad_req i_req,
    input  wire logic [7:0]          i_rom_bank,
    input  wire logic                i_boot_mapped,
    input  wire logic [7:0]          i_irq_enable,
    input  wire logic [7:0]          i_irq_flags,
    output hbad_pkg::t_hbad_dec      o_dec,
    output logic [MAIN_AW-1:0]       o_main_addr,
    output logic [SMALL_AW-1:0]      o_small_addr
);

    import hbad_pkg::*;

    logic [15:0] a;
    logic        wr;
    logic [12:0] ram_ofs;

    assign a       = i_req.address;
    assign wr      = (i_req.command == CMD_WRITE);
    assign ram_ofs = a[12:0] & ADDR_WRAM_MASK[12:0];

    always_comb begin
        o_dec              = '0;
        o_dec.we           = wr;
        o_dec.rsp.target   = TGT_INTERNAL;
        o_main_addr        = MAIN_AW'(ram_ofs);
        o_small_addr       = SMALL_AW'(a[7:0]);

        // Walk the memory map from the bottom up.
        if (i_boot_mapped && (a[15:8] == 8'h00)) begin
            o_dec.rsp.target         = wr ? TGT_DROP : TGT_BOOT;
            o_dec.rsp.target_address = wr ? '0 : 22'(a);
        end else if (a[15:14] == 2'b00) begin
            o_dec.rsp.target         = wr ? TGT_DROP : TGT_ROM;
            o_dec.rsp.target_address = wr ? '0 : 22'(a);
        end else if (a[15:14] == 2'b01) begin
            // Banked ROM: the bank number forms the upper address bits.
            o_dec.rsp.target         = wr ? TGT_DROP : TGT_ROM;
            o_dec.rsp.target_address = wr ? '0 : {i_rom_bank, a[13:0]};
        end else if (a[15:13] == 3'b100) begin
            o_dec.rsp.target         = TGT_VRAM;
            o_dec.rsp.target_address = 22'(a[12:0]);
            o_dec.rsp.forward_write  = wr;
        end else if (a[15:13] == 3'b101) begin
            // Cartridge RAM sits in the lower half of the main store.
            o_dec.main_en = 1'b1;
        end else if (a < ADDR_OAM_BASE) begin
            // Work RAM and its echo share the upper half of the main store.
            o_dec.main_en = 1'b1;
            o_main_addr   = MAIN_AW'(CART_RAM_BYTES) + MAIN_AW'(ram_ofs);
        end else if (a < ADDR_IO_BASE) begin
            // Sprite RAM; the gap above it reads zero and ignores writes.
            o_dec.small_en = (a < ADDR_OAM_END);
        end else if (a == ADDR_IRQ_EN) begin
            o_dec.ie_we         = wr;
            o_dec.rsp.read_data = i_irq_enable;
        end else if (a >= ADDR_HRAM_BASE) begin
            o_dec.small_en = 1'b1;
            o_small_addr   = SMALL_AW'(SPRITE_RAM_BYTES) + SMALL_AW'(a[6:0]);
        end else if (a == ADDR_IRQ_FLAGS) begin
            o_dec.if_we         = wr;
            o_dec.rsp.read_data = i_irq_flags;
        end else if (a >= ADDR_VREG_BASE) begin
            if (wr && (a == ADDR_BOOT_OFF) && (i_req.write_data == BOOT_OFF_KEY)) begin
                o_dec.boot_clr = 1'b1;
            end else begin
                o_dec.rsp.target         = TGT_VREG;
                o_dec.rsp.target_address = 22'(a);
                o_dec.rsp.forward_write  = wr;
            end
        end else begin
            o_dec.rsp.read_data = OPEN_BUS_BYTE;
        end

        // Writes never return data; forwarded writes carry the byte.
        if (wr) begin
            o_dec.rsp.read_data = '0;
        end
        o_dec.rsp.forward_data = o_dec.rsp.forward_write ? i_req.write_data : '0;
    end

endmodule

`default_nettype wire

[tb/sv/hbad_checker.sv]
// Response checker for the bus address decoder: predicts every response and compares it.
module hbad_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  hbad_pkg::t_hbad_req i_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  hbad_pkg::t_hbad_rsp i_rsp,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import hbad_pkg::*;

    // Region boundaries that the package does not name.
    localparam logic [15:0] BOOT_WINDOW_TOP = 16'h00FF;
    localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
    localparam logic [15:0] VRAM_BASE       = 16'h8000;
    localparam logic [15:0] CART_BASE       = 16'hA000;
    localparam logic [15:0] WRAM_BASE       = 16'hC000;
    localparam int          MAX_REPORTS     = 30;

    // Shadow copy of the block's stores, registers and ROM bank.
    logic [7:0] cart_mem   [0:CART_RAM_BYTES_C-1];
    logic [7:0] work_mem   [0:WORK_RAM_BYTES_C-1];
    logic [7:0] sprite_mem [0:SPRITE_RAM_BYTES_C-1];
    logic [7:0] high_mem   [0:HIGH_RAM_BYTES_C-1];
    logic [7:0] irq_enable_q;
    logic [7:0] irq_flags_q;
    logic [7:0] rom_bank_q;
    logic       boot_mapped_q;

    t_hbad_rsp awaited_rsps[$];
    t_hbad_rsp want;
    int        mismatches     = 0;
    int        responses_seen = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = responses_seen;

    // Print one mismatch line, up to a cap, and count it either way.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] predicted);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch at response %0d: %s is %0h, predicted %0h",
                     responses_seen, what, got, predicted);
        end
        mismatches++;
    endtask

    // Decode one bus request against the shadow state and apply its side effects.
    function automatic t_hbad_rsp decode_access(input t_hbad_req r);
        t_hbad_rsp   rsp;
        logic        wr;
        logic [15:0] a;
        logic [7:0]  d;
        rsp = '0;
        wr  = (r.command == CMD_WRITE);
        a   = r.address;
        d   = r.write_data;
        rsp.target = TGT_INTERNAL;
        if (boot_mapped_q && a <= BOOT_WINDOW_TOP) begin
            if (wr) begin
                rsp.target = TGT_DROP;
            end else begin
                rsp.target         = TGT_BOOT;
                rsp.target_address = {6'd0, a};
            end
        end else if (a < ROM_BANKED_BASE) begin
            if (wr) begin
                rsp.target = TGT_DROP;
            end else begin
                rsp.target         = TGT_ROM;
                rsp.target_address = {6'd0, a};
            end
        end else if (a < VRAM_BASE) begin
            // Banked window: the bank number lands above the 14-bit offset.
            if (wr) begin
                rsp.target = TGT_DROP;
            end else begin
                rsp.target         = TGT_ROM;
                rsp.target_address = {rom_bank_q, a[13:0]};
            end
        end else if (a < CART_BASE) begin
            rsp.target         = TGT_VRAM;
            rsp.target_address = {9'd0, a[12:0]};
            rsp.forward_write  = wr;
        end else if (a < WRAM_BASE) begin
            if (wr) cart_mem[a[12:0]] = d;
            else rsp.read_data = cart_mem[a[12:0]];
        end else if (a < ADDR_OAM_BASE) begin
            // Work RAM and its echo share the low 13 address bits.
            if (wr) work_mem[a[12:0]] = d;
            else rsp.read_data = work_mem[a[12:0]];
        end else if (a < ADDR_IO_BASE) begin
            // Past the sprite table the gap reads zero and ignores writes.
            if (a < ADDR_OAM_END) begin
                if (wr) sprite_mem[a[7:0]] = d;
                else rsp.read_data = sprite_mem[a[7:0]];
            end
        end else if (a == ADDR_IRQ_EN) begin
            if (wr) irq_enable_q = d;
            else rsp.read_data = irq_enable_q;
        end else if (a >= ADDR_HRAM_BASE) begin
            if (wr) high_mem[a[6:0]] = d;
            else rsp.read_data = high_mem[a[6:0]];
        end else if (a == ADDR_IRQ_FLAGS) begin
            if (wr) irq_flags_q = d;
            else rsp.read_data = irq_flags_q;
        end else if (a >= ADDR_VREG_BASE) begin
            // The unmap key is consumed here; any other byte goes to the video side.
            if (wr && a == ADDR_BOOT_OFF && d == BOOT_OFF_KEY) begin
                boot_mapped_q = 1'b0;
            end else begin
                rsp.target         = TGT_VREG;
                rsp.target_address = {6'd0, a};
                rsp.forward_write  = wr;
            end
        end else begin
            if (!wr) rsp.read_data = OPEN_BUS_BYTE;
        end
        if (wr) rsp.read_data = 8'd0;
        rsp.forward_data = rsp.forward_write ? d : 8'd0;
        return rsp;
    endfunction

    // Follow all three channels; responses are retired before new requests are queued.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rom_bank_q    = 8'd1;
            irq_enable_q  = 8'd0;
            irq_flags_q   = 8'd0;
            boot_mapped_q = 1'b1;
            awaited_rsps.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) rom_bank_q = i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsps.size() == 0) begin
                    report_mismatch("response with no request outstanding", 64'(i_rsp),
                                    64'd0);
                end else begin
                    want = awaited_rsps.pop_front();
                    if (i_rsp.target !== want.target)
                        report_mismatch("target", 64'(i_rsp.target), 64'(want.target));
                    if (i_rsp.target_address !== want.target_address)
                        report_mismatch("target_address", 64'(i_rsp.target_address),
                                        64'(want.target_address));
                    if (i_rsp.read_data !== want.read_data)
                        report_mismatch("read_data", 64'(i_rsp.read_data),
                                        64'(want.read_data));
                    if (i_rsp.forward_write !== want.forward_write)
                        report_mismatch("forward_write", 64'(i_rsp.forward_write),
                                        64'(want.forward_write));
                    if (i_rsp.forward_data !== want.forward_data)
                        report_mismatch("forward_data", 64'(i_rsp.forward_data),
                                        64'(want.forward_data));
                end
                responses_seen++;
            end
            if (i_req_valid && i_req_ready) awaited_rsps.push_back(decode_access(i_req));
            o_pending <= awaited_rsps.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the bus address decoder: clock, reset, request traffic and verdict.
module tb_top;
    import hbad_pkg::*;

    localparam int ITEMS_PER_PHASE = 440;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RESET_CYCLES    = 12;

    localparam logic [15:0] CART_BASE = 16'hA000;
    localparam logic [15:0] WRAM_BASE = 16'hC000;
    localparam logic [15:0] ECHO_BASE = 16'hE000;
    localparam logic [12:0] ECHO_SPAN = 13'h1E00;

    // One flat map of store entries, so reads only go where a write has been.
    localparam int SLOT_WORK   = CART_RAM_BYTES_C;
    localparam int SLOT_SPRITE = SLOT_WORK + WORK_RAM_BYTES_C;
    localparam int SLOT_HIGH   = SLOT_SPRITE + SPRITE_RAM_BYTES_C;
    localparam int SLOT_COUNT  = SLOT_HIGH + HIGH_RAM_BYTES_C;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    t_hbad_req  req_q     = '0;
    logic       req_ready;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    t_hbad_rsp  rsp;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    logic       cfg_ready;

    int          fail_count;
    int          pending;
    int          checked;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          sent         = 0;
    int          stall_cycles = 0;
    logic        keep_boot    = 1'b1;
    logic [12:0] hot_base     = '0;
    logic [7:0]  last_bank    = 8'd0;
    bit          written [0:SLOT_COUNT-1];

    always #5 clk = ~clk;

    handheld_bus_address_decoder_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_q),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    hbad_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_q),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // The response side stalls at random at the current rate.
    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: give up when no channel has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: %0d cycles with no channel moving", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Draw one request, weighted toward the stores and the special addresses.
    function automatic t_hbad_req pick_access();
        t_hbad_req   r;
        int unsigned sel;
        logic [15:0] rnd;
        logic [12:0] idx;
        r.command    = 1'($urandom_range(1));
        r.write_data = 8'($urandom);
        rnd          = 16'($urandom);
        idx          = 13'($urandom);
        sel          = $urandom_range(99);
        // Most store traffic stays in a small window so reads find earlier writes.
        if ($urandom_range(99) < 70) idx = hot_base + idx[4:0];
        if (sel < 4) begin
            r.address = {8'h00, rnd[7:0]};
        end else if (sel < 10) begin
            r.address = {2'b00, rnd[13:0]};
        end else if (sel < 20) begin
            r.address = {2'b01, rnd[13:0]};
        end else if (sel < 28) begin
            r.address = {3'b100, rnd[12:0]};
        end else if (sel < 42) begin
            r.address = CART_BASE + idx;
        end else if (sel < 58) begin
            if (idx < ECHO_SPAN && rnd[15]) r.address = ECHO_BASE + idx;
            else r.address = WRAM_BASE + idx;
        end else if (sel < 66) begin
            r.address = ADDR_OAM_BASE + (idx % 13'd160);
        end else if (sel < 70) begin
            r.address = ADDR_OAM_END + (rnd[7:0] % 8'd96);
        end else if (sel < 82) begin
            // I/O page, leaning on the interrupt flags and the boot ROM switch.
            case (rnd[1:0])
                2'd0: r.address = ADDR_IRQ_FLAGS;
                2'd1: r.address = ADDR_BOOT_OFF;
                default: r.address = {9'h1FE, rnd[8:2]};
            endcase
            if (r.address == ADDR_BOOT_OFF && rnd[14]) r.write_data = BOOT_OFF_KEY;
        end else if (sel < 90) begin
            r.address = {9'h1FF, idx[6:0]};
        end else if (sel < 95) begin
            r.address = ADDR_IRQ_EN;
        end else begin
            r.address = rnd;
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic issue(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
        t_hbad_req q;
        int        slot;
        q.command    = cmd;
        q.address    = addr;
        q.write_data = data;
        if (keep_boot && cmd == CMD_WRITE && addr == ADDR_BOOT_OFF && data == BOOT_OFF_KEY)
            q.write_data = 8'h02;
        slot = -1;
        if (addr >= CART_BASE && addr < WRAM_BASE) slot = int'(addr[12:0]);
        else if (addr >= WRAM_BASE && addr < ADDR_OAM_BASE) slot = SLOT_WORK + addr[12:0];
        else if (addr >= ADDR_OAM_BASE && addr < ADDR_OAM_END) slot = SLOT_SPRITE + addr[7:0];
        else if (addr >= ADDR_HRAM_BASE && addr != ADDR_IRQ_EN) slot = SLOT_HIGH + addr[6:0];
        // A read of a byte never stored becomes a write to it.
        if (slot >= 0) begin
            if (q.command == CMD_READ && !written[slot]) q.command = CMD_WRITE;
            if (q.command == CMD_WRITE) written[slot] = 1'b1;
        end
        while ($urandom_range(99) < snd_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_q     <= q;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent++;
    endtask

    task automatic run_random(input int count);
        t_hbad_req r;
        hot_base = 13'($urandom);
        repeat (count) begin
            r = pick_access();
            issue(r.command, r.address, r.write_data);
        end
    endtask

    // Stop sending and wait until every outstanding response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_bank(input logic [7:0] bank);
        cfg_valid <= 1'b1;
        cfg_data  <= bank;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        last_bank = bank;
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with the reset ROM bank and the boot ROM still mapped.
        issue(CMD_READ,  16'h0000, 8'h00);
        issue(CMD_READ,  16'h00FF, 8'hFF);
        issue(CMD_WRITE, 16'h0010, 8'h33);
        issue(CMD_READ,  16'h3FFF, 8'h00);
        issue(CMD_WRITE, 16'h3FFF, 8'h44);
        issue(CMD_READ,  16'h4000, 8'h00);
        issue(CMD_READ,  16'h7FFF, 8'h00);
        issue(CMD_WRITE, 16'h8000, 8'h00);
        issue(CMD_READ,  16'h9FFF, 8'h00);
        issue(CMD_WRITE, 16'hA000, 8'hFF);
        issue(CMD_READ,  16'hA000, 8'h00);
        issue(CMD_WRITE, 16'hC000, 8'h5A);
        issue(CMD_READ,  16'hE000, 8'h00);
        issue(CMD_WRITE, 16'hFDFF, 8'hA5);
        issue(CMD_READ,  16'hDDFF, 8'h00);
        issue(CMD_WRITE, 16'hFE9F, 8'hC3);
        issue(CMD_READ,  16'hFE9F, 8'h00);
        issue(CMD_WRITE, 16'hFEA0, 8'h77);
        issue(CMD_READ,  16'hFEFF, 8'h00);
        issue(CMD_WRITE, ADDR_IRQ_FLAGS, 8'hFF);
        issue(CMD_READ,  ADDR_IRQ_FLAGS, 8'h00);
        issue(CMD_WRITE, ADDR_IRQ_EN, 8'h81);
        issue(CMD_READ,  ADDR_IRQ_EN, 8'h00);
        issue(CMD_WRITE, ADDR_HRAM_BASE, 8'h3C);
        issue(CMD_READ,  ADDR_HRAM_BASE, 8'h00);
        issue(CMD_READ,  ADDR_IO_BASE, 8'h00);
        issue(CMD_WRITE, ADDR_BOOT_OFF, 8'h02);
        issue(CMD_READ,  ADDR_BOOT_OFF, 8'h00);
        drain();

        // Light sender gaps, heavy response stalls, top ROM bank, boot ROM kept.
        set_bank(8'hFF);
        snd_idle_pct = 9;
        rcv_idle_pct = 49;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Unmap the boot ROM, then swap the stall rates with bank zero.
        keep_boot = 1'b0;
        issue(CMD_WRITE, ADDR_BOOT_OFF, BOOT_OFF_KEY);
        drain();
        set_bank(8'h00);
        snd_idle_pct = 49;
        rcv_idle_pct = 9;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Back-to-back traffic on a random bank.
        set_bank(8'($urandom_range(254, 1)));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bus requests and checked %0d responses across directed,",
                 sent, checked);
        $display("stalled and back-to-back traffic; ROM banks 1, 255, 0 and %0d.", last_bank);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
